// ===== hdl/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int UnitW = 21;

  localparam logic [UnitW-1:0] REPL_CHAR   = 21'h00FFFD;
  localparam logic [UnitW-1:0] BMP_MAX     = 21'h00FFFF;
  localparam logic [UnitW-1:0] SUPP_BASE   = 21'h010000;
  localparam logic [15:0]      HI_SURR     = 16'hD800;
  localparam logic [5:0]       LO_SURR_TOP = 6'b110111;   // 0xDC00 >> 10

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR = 3'd4;

  localparam int MaxRes = 4;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             replaced;
    logic             last;
  } out_word_t;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             replaced;
  } res_t;

  // decoder state
  typedef struct packed {
    logic [2:0]       exp_len;
    logic [1:0]       taken;
    logic [UnitW-1:0] gathered;
  } dec_state_t;

  // everything one byte produces
  typedef struct packed {
    dec_state_t          nxt;
    res_t [MaxRes-1:0]   res;
    logic [2:0]          cnt;
  } dec_out_t;

endpackage

// ===== hdl/u8d_decode.sv =====
// ----------------------------------------------------------------------------
// u8d_decode
// Single-pass decode of one text byte against the pending sequence state:
// next state plus the list of up to four result words.
// ----------------------------------------------------------------------------
module u8d_decode import u8d_pkg::*; (
  input  dec_state_t cur,
  input  in_word_t   din,
  input  logic       utf16_mode,
  output dec_out_t   dout
);

  always_comb begin
    logic [7:0]       b;
    logic             pending;
    logic             is_cont;
    logic [UnitW-1:0] shifted;
    logic [2:0]       taken_inc;
    dec_state_t       st;
    logic [1:0]       f1;
    logic [1:0]       f2;
    logic             pt_valid;
    logic [UnitW-1:0] pt;
    logic             pt_repl;
    logic [1:0]       np;
    logic [UnitW-1:0] v;
    logic [15:0]      hi_unit;
    logic [UnitW-1:0] u0;
    logic [UnitW-1:0] u1;
    logic [2:0]       total;
    logic [2:0]       j;

    b         = din.text_byte;
    pending   = (cur.exp_len != LEN_NONE);
    is_cont   = (b[7:6] == 2'b10);
    shifted   = {cur.gathered[UnitW-7:0], b[5:0]};
    taken_inc = {1'b0, cur.taken} + 3'd1;
    st        = cur;
    f1        = 2'd0;
    f2        = 2'd0;
    pt_valid  = 1'b0;
    pt        = '0;
    pt_repl   = 1'b0;

    if (pending && is_cont) begin
      if (taken_inc >= cur.exp_len) begin
        pt_valid = 1'b1;
        pt       = shifted;
        st       = '0;
      end else begin
        st.taken    = taken_inc[1:0];
        st.gathered = shifted;
      end
    end else begin
      if (pending) begin
        // broken sequence: one replacement per byte already taken
        f1 = cur.taken;
        st = '0;
      end
      if (!b[7]) begin
        pt_valid = 1'b1;
        pt       = {13'd0, b};
      end else if (b[7:5] == 3'b110) begin
        st.exp_len  = LEN_TWO;
        st.taken    = 2'd1;
        st.gathered = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
        st.exp_len  = LEN_THREE;
        st.taken    = 2'd1;
        st.gathered = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        st.exp_len  = LEN_FOUR;
        st.taken    = 2'd1;
        st.gathered = {18'd0, b[2:0]};
      end else begin
        pt_valid = 1'b1;
        pt       = REPL_CHAR;
        pt_repl  = 1'b1;
      end
    end

    if (din.end_of_text) begin
      if (st.exp_len != LEN_NONE) begin
        f2 = st.taken;
      end
      st = '0;
    end

    // surrogate split
    v       = pt - SUPP_BASE;
    hi_unit = HI_SURR + {5'd0, v[20:10]};
    if (utf16_mode && (pt > BMP_MAX)) begin
      np = pt_valid ? 2'd2 : 2'd0;
      u0 = {5'd0, hi_unit};
      u1 = {5'd0, LO_SURR_TOP, v[9:0]};
    end else begin
      np = pt_valid ? 2'd1 : 2'd0;
      u0 = pt;
      u1 = pt;
    end

    total = {1'b0, f1} + {1'b0, np} + {1'b0, f2};
    dout.cnt = (total > 3'd4) ? 3'd4 : total;
    dout.nxt = st;

    // flush words, then the point, then the end-of-text flush
    for (int i = 0; i < MaxRes; i++) begin
      j = 3'(i) - {1'b0, f1};
      if (3'(i) < {1'b0, f1}) begin
        dout.res[i] = '{unit: REPL_CHAR, replaced: 1'b1};
      end else if (j < {1'b0, np}) begin
        dout.res[i] = '{unit: (j[0] ? u1 : u0), replaced: pt_repl};
      end else begin
        dout.res[i] = '{unit: REPL_CHAR, replaced: 1'b1};
      end
    end
  end

endmodule

// ===== hdl/utf8_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// UTF-8 byte stream to code points or UTF-16 code units, with U+FFFD
// replacement of malformed bytes.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | word
//  in      | in  | in_valid / in_stall | in_word_t  {text_byte, end_of_text}
//  out     | out | out_valid/out_stall | out_word_t {unit, replaced, last}
//  cfg     | in  | cfg_valid/cfg_ready | utf16_mode bit
//
//  A byte is decoded in the cycle it is accepted; its results show from the
//  next cycle, one word per cycle unless out_stall, from a four-entry burst
//  register. With out_stall low, a byte with at most one result sustains one
//  byte per cycle; one with n results holds the register until all n leave.
//  in_stall is high while the burst register holds words other than the one
//  leaving this cycle. Synchronous reset clears decode state and the mode.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic              mode;
  dec_state_t        state;
  dec_out_t          dec;
  res_t [MaxRes-1:0] burst;
  logic [2:0]        cnt;
  logic [1:0]        idx;
  logic              busy;
  logic              take;
  logic              is_last;
  logic              accept;

  u8d_decode u_decode (
    .cur        (state),
    .din        (in_data),
    .utf16_mode (mode),
    .dout       (dec)
  );

  assign is_last   = ({1'b0, idx} == (cnt - 3'd1));
  assign take      = busy && !out_stall;
  assign in_stall  = busy && !(take && is_last);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign out_valid         = busy;
  assign out_data.unit     = burst[idx].unit;
  assign out_data.replaced = burst[idx].replaced;
  assign out_data.last     = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= 1'b0;
      state <= '0;
      busy  <= 1'b0;
      cnt   <= 3'd0;
      idx   <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      if (accept) begin
        state <= dec.nxt;
      end
      if (accept && (dec.cnt != 3'd0)) begin
        busy <= 1'b1;
        cnt  <= dec.cnt;
        idx  <= 2'd0;
      end else if (take) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
    end
  end

  // burst payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept && (dec.cnt != 3'd0)) begin
      burst <= dec.res;
    end
  end

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no word pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cnt != 3'd0) && (cnt <= 3'd4) && ({1'b0, idx} < cnt))
    else $error("burst count or index out of range");

  a_burst_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !out_data.last) |=> out_valid)
    else $error("burst ended before last word");

  a_state_valid: assert property (@(posedge clk) disable iff (rst)
    (state.exp_len == LEN_NONE) |-> (state.taken == 2'd0))
    else $error("bytes taken with no sequence pending");

endmodule

// ===== dv/utf8_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top_tb
// Feeds UTF-8 text (directed cases, then random well-formed and broken byte
// sequences) into the decoder with random gaps and output stalls in both
// modes, decodes the same bytes in a behavioral model and checks every
// output word in order.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top_tb;
  import u8d_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data = 1'b0;

  utf8_stream_decoder_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  in_word_t  text_q[$];      // bytes waiting to be offered
  out_word_t decoded_q[$];   // units decoded by the model, not yet seen
  out_word_t byte_units[$];  // units caused by the byte being decoded
  out_word_t want;

  int fail_cnt = 0;
  int queued_bytes = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;
  bit hold_go = 1'b0;
  logic hold_on = 1'b0;

  // model decoder state
  logic             mode_utf16 = 1'b0;
  logic [2:0]       seq_len = LEN_NONE;
  logic [1:0]       seq_taken = 2'd0;
  logic [UnitW-1:0] seq_bits = '0;

  function automatic void flag(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------- decoder model ----------------

  function automatic void add_unit(logic [UnitW-1:0] u, logic repl);
    out_word_t w;
    w.unit = u;
    w.replaced = repl;
    w.last = 1'b0;
    if (byte_units.size() < MaxRes) byte_units = {byte_units, w};
  endfunction

  function automatic void emit_cp(logic [UnitW-1:0] cp, logic repl);
    logic [UnitW-1:0] v;
    logic [15:0] hi;
    if (mode_utf16 && cp > BMP_MAX) begin
      v = cp - SUPP_BASE;
      hi = HI_SURR + {5'd0, v[20:10]};
      add_unit({5'd0, hi}, repl);
      add_unit({5'd0, LO_SURR_TOP, v[9:0]}, repl);
    end else begin
      add_unit(cp, repl);
    end
  endfunction

  // one replacement per byte of a sequence that never completed
  function automatic void flush_seq();
    if (seq_len != LEN_NONE) begin
      for (int k = 0; k < seq_taken; k++) emit_cp(REPL_CHAR, 1'b1);
    end
    seq_len = LEN_NONE;
    seq_taken = 2'd0;
    seq_bits = '0;
  endfunction

  function automatic void decode_byte(in_word_t w);
    logic as_lead;
    as_lead = 1'b1;
    byte_units.delete();
    if (seq_len != LEN_NONE) begin
      if (w.text_byte[7:6] == 2'b10) begin
        as_lead = 1'b0;
        seq_bits = {seq_bits[14:0], w.text_byte[5:0]};
        if ({1'b0, seq_taken} + 3'd1 >= seq_len) begin
          emit_cp(seq_bits, 1'b0);
          seq_len = LEN_NONE;
          seq_taken = 2'd0;
          seq_bits = '0;
        end else begin
          seq_taken = seq_taken + 2'd1;
        end
      end else begin
        flush_seq();
      end
    end
    if (as_lead) begin
      casez (w.text_byte)
        8'b0???????: emit_cp({13'd0, w.text_byte}, 1'b0);
        8'b110?????: begin
          seq_len = LEN_TWO;
          seq_taken = 2'd1;
          seq_bits = {16'd0, w.text_byte[4:0]};
        end
        8'b1110????: begin
          seq_len = LEN_THREE;
          seq_taken = 2'd1;
          seq_bits = {17'd0, w.text_byte[3:0]};
        end
        8'b11110???: begin
          seq_len = LEN_FOUR;
          seq_taken = 2'd1;
          seq_bits = {18'd0, w.text_byte[2:0]};
        end
        default: emit_cp(REPL_CHAR, 1'b1);
      endcase
    end
    if (w.end_of_text) flush_seq();
    if (byte_units.size() > 0) byte_units[byte_units.size() - 1].last = 1'b1;
    foreach (byte_units[i]) decoded_q = {decoded_q, byte_units[i]};
  endfunction

  // ---------------- text generation ----------------

  function automatic void put_byte(logic [7:0] b, logic eot);
    in_word_t w;
    w.text_byte = b;
    w.end_of_text = eot;
    text_q = {text_q, w};
    queued_bytes++;
  endfunction

  function automatic logic rnd_eot();
    return ($urandom_range(0, 24) == 0);
  endfunction

  // lead byte of a len-byte character, then continuation bytes up to take
  function automatic void put_char(int len, int take);
    logic [7:0] lead;
    case (len)
      1:       lead = 8'($urandom_range(0, 127));
      2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
      3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
      default: lead = 8'hF0 | 8'($urandom_range(0, 7));
    endcase
    put_byte(lead, rnd_eot());
    for (int k = 1; k < take; k++) put_byte(8'h80 | 8'($urandom_range(0, 63)), rnd_eot());
  endfunction

  function automatic void add_random_text(int n);
    int start;
    int r;
    int len;
    start = queued_bytes;
    while (queued_bytes - start < n) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (r < 75) begin
        put_char(len, len);
      end else if (r < 85) begin
        put_byte(8'($urandom_range(0, 255)), rnd_eot());
      end else if (r < 95) begin
        len = $urandom_range(2, 4);
        put_char(len, $urandom_range(1, len - 1));
      end else begin
        put_byte(8'($urandom_range(128, 191)), rnd_eot());
      end
    end
  endfunction

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) decode_byte(in_data);
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (text_q.size() > 0) begin
          in_data <= text_q.pop_front();
          in_valid <= 1'b1;
          send_gap = idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          flag($sformatf("unexpected word unit=%h replaced=%b last=%b",
                         out_data.unit, out_data.replaced, out_data.last));
        end else begin
          want = decoded_q.pop_front();
          if (out_data.unit !== want.unit)
            flag($sformatf("unit: expected %h, got %h", want.unit, out_data.unit));
          if (out_data.replaced !== want.replaced)
            flag($sformatf("replaced: expected %b, got %b (unit %h)",
                           want.replaced, out_data.replaced, want.unit));
          if (out_data.last !== want.last)
            flag($sformatf("last: expected %b, got %b (unit %h)",
                           want.last, out_data.last, want.unit));
        end
      end
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      out_stall <= hold_on || (stall_left > 0);
    end
  end

  // long receiver hold-off so the burst register fills and input backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (200) @(posedge clk);
    hold_on <= 1'b0;
  end

  // ---------------- sequencing ----------------

  task automatic write_mode(logic v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_utf16 = v;
  endtask

  task automatic settle();
    int guard;
    guard = 0;
    do begin
      @(posedge clk);
      guard++;
    end while ((text_q.size() != 0 || in_valid || decoded_q.size() != 0) && guard < 20000);
    if (decoded_q.size() != 0) begin
      flag($sformatf("%0d decoded units never came out", decoded_q.size()));
      decoded_q.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    write_mode(1'b0);
    put_byte(8'h7F, 1'b0);                       // ASCII extremes
    put_byte(8'h00, 1'b1);
    put_byte(8'hE2, 1'b0);                       // 3-byte char
    put_byte(8'h82, 1'b0);
    put_byte(8'hAC, 1'b0);
    put_byte(8'hF0, 1'b0);                       // 4-byte char above the BMP
    put_byte(8'h9F, 1'b0);
    put_byte(8'h98, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'h80, 1'b0);                       // stray continuation
    put_byte(8'hFF, 1'b0);                       // 11111xxx lead
    put_byte(8'hE2, 1'b0);                       // broken, then a 2-byte char
    put_byte(8'h82, 1'b0);
    put_byte(8'hC2, 1'b0);
    put_byte(8'hA9, 1'b0);
    put_byte(8'hF4, 1'b0);                       // cut short by end of text
    put_byte(8'h8F, 1'b1);
    put_byte(8'hF7, 1'b0);                       // largest 4-byte value
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hBF, 1'b0);
    put_byte(8'hF0, 1'b0);                       // four replacements from one byte
    put_byte(8'h90, 1'b0);
    put_byte(8'h80, 1'b0);
    put_byte(8'hC3, 1'b1);
    settle();

    write_mode(1'b1);
    add_random_text(60);
    settle();

    no_idle = 1'b1;
    write_mode(1'b0);
    add_random_text(50);
    settle();
    no_idle = 1'b0;

    write_mode(1'b1);
    hold_go = 1'b1;
    add_random_text(40);
    settle();

    if (fail_cnt == 0) begin
      $display("** utf8_stream_decoder_top: PASSED **");
    end else begin
      $display("** utf8_stream_decoder_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** utf8_stream_decoder_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/utf8_stream_decoder_top.sv
dv/utf8_stream_decoder_top_tb.sv
